// ===== design/rdc_pkg.sv =====
// rdc_pkg: shared types, widths and constants of the radix digit converter
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package rdc_pkg;

	localparam int VALUE_W     = 32;   // width of the input value field
	localparam int RADIX_W     = 5;    // width of the radix register
	localparam int DIGIT_W     = 4;    // width of one digit
	localparam int CHAR_W      = 7;    // width of an ascii code
	localparam int RADIX_MIN   = 2;
	localparam int RADIX_MAX   = 16;
	localparam int RADIX_RESET = 10;
	localparam int QUEUE_DEPTH = 2;    // entries between front and back
	localparam int CHAR_ZERO   = 48;   // ascii '0'
	localparam int CHAR_A_OFS  = 55;   // ascii 'A' minus ten

	// one classified item as it travels from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] value;      // value already masked to the operand width
		logic [RADIX_W-1:0] base;       // radix in force when the item was taken
		logic               one_digit;  // value below base: single digit, no division
	} rdc_item_t;

	typedef struct packed {
		logic      valid;
		rdc_item_t item;
	} rdc_push_t;

	typedef struct packed {
		logic      avail;
		rdc_item_t item;
	} rdc_qhead_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = CHAR_W'(d);
		if (d < DIGIT_W'(10)) begin
			return CHAR_W'(CHAR_ZERO) + d_ext;
		end else begin
			return CHAR_W'(CHAR_A_OFS) + d_ext;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/rdc_if.sv =====
// rdc_in_if / rdc_out_if: valid-ready channels of the radix digit converter
// depends on rdc_pkg for the payload widths
`default_nettype none

interface rdc_in_if;
	import rdc_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
	import rdc_pkg::*;

	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic [CHAR_W-1:0]  digit_char;
	logic               last;

	modport source (output valid, output digit, output digit_char, output last, input ready);
	modport sink   (input valid, input digit, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// ===== design/rdc_front.sv =====
// rdc_front: radix register, input transfer, masking and classification
// depends on rdc_pkg and rdc_in_if
`default_nettype none

module rdc_front #(
	parameter int VALUE_BITS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [rdc_pkg::RADIX_W-1:0]  cfg_wdata,
	rdc_in_if.sink                       in_ch,
	output rdc_pkg::rdc_push_t           push,
	input  wire                          push_ready
);
	import rdc_pkg::*;

	localparam int NB = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] radix_clamped;
	logic [VALUE_W-1:0] value_masked;

	// clamp written base to 2..16
	always_comb begin
		if (cfg_wdata < RADIX_W'(RADIX_MIN)) begin
			radix_clamped = RADIX_W'(RADIX_MIN);
		end else if (cfg_wdata > RADIX_W'(RADIX_MAX)) begin
			radix_clamped = RADIX_W'(RADIX_MAX);
		end else begin
			radix_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_W'(RADIX_RESET);
		end else if (cfg_we) begin
			radix_q <= radix_clamped;
		end
	end

	assign value_masked = VALUE_W'(in_ch.value[NB-1:0]);

	assign in_ch.ready          = push_ready;
	assign push.valid           = in_ch.valid;
	assign push.item.value      = value_masked;
	assign push.item.base       = radix_q;
	assign push.item.one_digit  = value_masked < VALUE_W'(radix_q);

endmodule

`default_nettype wire

// ===== design/rdc_queue.sv =====
// rdc_queue: short fifo of classified items between front and back
// depends on rdc_pkg
`default_nettype none

module rdc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  rdc_pkg::rdc_push_t    push,
	output logic                  push_ready,
	output rdc_pkg::rdc_qhead_t   head,
	input  wire                   pop
);
	import rdc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	rdc_item_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != '0);

	assign head.avail = count_q != '0;
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && count_q == '0))
		else $error("rdc_queue: pop while empty");

endmodule

`default_nettype wire

// ===== design/rdc_back.sv =====
// rdc_back: restoring divider, digit store and most-significant-first output
// depends on rdc_pkg and rdc_out_if
`default_nettype none

module rdc_back #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rdc_pkg::rdc_qhead_t  head,
	output logic                 pop,
	rdc_out_if.source            out_ch
);
	import rdc_pkg::*;

	localparam int NB = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int SW = $clog2(NB);
	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_READ = 4'b0100,
		S_SHOW = 4'b1000
	} back_state_t;

	back_state_t         state_q;
	logic [NB-1:0]       quo_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  base_q;
	logic [SW-1:0]       step_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [DIGIT_W-1:0]  rd_data_q;
	logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];

	logic [RADIX_W-1:0]  trial;
	logic                trial_ge;
	logic [RADIX_W-1:0]  rem_nxt;
	logic [NB-1:0]       quo_nxt;
	logic [CW-1:0]       cnt_inc;
	logic                div_last_step;
	logic                conv_done;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [DIGIT_W-1:0]  mem_wdata;

	// one restoring step: bring down the next dividend bit
	assign trial    = {rem_q, quo_q[NB-1]};
	assign trial_ge = trial >= base_q;
	assign rem_nxt  = trial_ge ? (trial - base_q) : trial;
	assign quo_nxt  = {quo_q[NB-2:0], trial_ge};
	assign cnt_inc  = cnt_q + 1'b1;

	assign div_last_step = (state_q == S_DIV) && (step_q == '0);
	assign conv_done     = (quo_nxt == '0) || (cnt_inc == CW'(MAX_DIGITS));

	assign pop = (state_q == S_IDLE) && head.avail;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = rem_nxt[DIGIT_W-1:0];
		if (pop && head.item.one_digit) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = head.item.value[DIGIT_W-1:0];
		end else if (div_last_step) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_READ) begin
			rd_data_q <= digit_mem[rd_ptr_q];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			base_q <= head.item.base;
			quo_q  <= head.item.value[NB-1:0];
			rem_q  <= '0;
		end else if (state_q == S_DIV) begin
			quo_q <= quo_nxt;
			rem_q <= (div_last_step && !conv_done) ? '0 : rem_nxt[DIGIT_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (head.avail) begin
						cnt_q  <= '0;
						step_q <= SW'(NB - 1);
						if (head.item.one_digit) begin
							rd_ptr_q <= '0;
							state_q  <= S_READ;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (step_q == '0) begin
						cnt_q <= cnt_inc;
						if (conv_done) begin
							rd_ptr_q <= cnt_q[AW-1:0];
							state_q  <= S_READ;
						end else begin
							step_q <= SW'(NB - 1);
						end
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (out_ch.ready) begin
						if (rd_ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
							state_q  <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid      = state_q == S_SHOW;
	assign out_ch.digit      = rd_data_q;
	assign out_ch.digit_char = digit_to_char(rd_data_q);
	assign out_ch.last       = rd_ptr_q == '0;

	a_digit_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHOW) |-> (RADIX_W'(rd_data_q) < base_q))
		else $error("rdc_back: digit not below base");

	a_base_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (base_q >= RADIX_W'(RADIX_MIN) && base_q <= RADIX_W'(RADIX_MAX)))
		else $error("rdc_back: base out of range during division");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (RADIX_W'(rem_q) < base_q))
		else $error("rdc_back: partial remainder not below base");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < CW'(MAX_DIGITS)))
		else $error("rdc_back: digit store overrun");

endmodule

`default_nettype wire

// ===== design/radix_digit_converter_top.sv =====
// radix_digit_converter_top: value to base-n digit converter, top level
// depends on rdc_pkg, rdc_if, rdc_front, rdc_queue and rdc_back
// a value below the base skips the divider and goes from the queue straight
// to the read and show states; otherwise the one-bit restoring divider works
// through all NB operand bits for each digit (NB = min(VALUE_BITS, 32)), then
// the digits go out most significant first, each through the read and show states;
// while a conversion runs, up to 2 further items wait in the queue
// reset: radix returns to 10, queue empties, back end idles; no clearing pass
`default_nettype none

module radix_digit_converter_top #(
	parameter int VALUE_BITS = 32,   // operand bits taken from value (at most 32), 8..64
	parameter int MAX_DIGITS = 32    // depth of the digit store, 8..64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [rdc_pkg::RADIX_W-1:0]  cfg_wdata,
	rdc_in_if.sink                       in_ch,
	rdc_out_if.source                    out_ch
);
	import rdc_pkg::*;

	// front to queue and queue to back
	rdc_push_t  push;
	logic       push_ready;
	rdc_qhead_t head;
	logic       pop;

	// front: holds the clamped radix, masks each value and flags the
	// single-digit case so the back end can skip the divider for it
	rdc_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.push       (push),
		.push_ready (push_ready)
	);

	// queue: lets input transfers continue while a long conversion runs
	rdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// back: repeated division by the base, digits stored least significant
	// first, then read back in reverse order, one output transfer per digit
	rdc_back #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

// ===== verif/radix_digit_converter_top_test.sv =====
// radix_digit_converter_top_test: self-checking bench for the radix digit converter
// depends on rdc_pkg, rdc_in_if / rdc_out_if and radix_digit_converter_top
// drives values and radix writes, predicts the digit stream, checks every transfer
`timescale 1ns / 1ps

module radix_digit_converter_top_test;
	import rdc_pkg::*;

	localparam int VALUE_BITS     = 32;
	localparam int MAX_DIGITS     = 32;
	localparam int DECIMAL_DIGITS = 10;       // digits below this print as '0'..'9'
	localparam int ASCII_0        = 48;
	localparam int ASCII_A        = 65;
	localparam int SETTLE_CYCLES  = 64;       // quiet time after the last digit
	localparam int HOLD_CYCLES    = 3000;     // long receiver hold-off
	localparam int HOLD_AFTER     = 400;      // digits seen before the hold-off starts
	localparam int RANDOM_ITEMS   = 41;       // per radix phase, ten phases
	localparam int REPORT_CAP     = 40;       // mismatched transfers reported at most
	localparam longint CYCLE_LIMIT = 3000000;
	localparam bit [63:0] OPERAND_MASK =
		(VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [CHAR_W-1:0]  digit_char;
		logic               last;
	} digit_t;

	// tracks the radix in force and the digits still owed by the block
	class digit_tracker;
		int unsigned radix_now;
		digit_t      owed_digits[$];
		int unsigned mismatches;

		function new();
			radix_now  = RADIX_RESET;
			mismatches = 0;
		endfunction

		function void set_radix(input logic [RADIX_W-1:0] wdata);
			if (wdata < RADIX_MIN) begin
				radix_now = RADIX_MIN;
			end else if (wdata > RADIX_MAX) begin
				radix_now = RADIX_MAX;
			end else begin
				radix_now = wdata;
			end
		endfunction

		function logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
			if (d < DECIMAL_DIGITS) begin
				return CHAR_W'(ASCII_0 + d);
			end else begin
				return CHAR_W'(ASCII_A + d - DECIMAL_DIGITS);
			end
		endfunction

		// repeated division, least significant first, then emit top down
		function void note_value(input logic [VALUE_W-1:0] v);
			bit [63:0]          rest;
			logic [DIGIT_W-1:0] lsd_first[$];
			int                 kept;
			digit_t             d;
			rest = 64'(v) & OPERAND_MASK;
			do begin
				lsd_first.push_back(DIGIT_W'(rest % radix_now));
				rest = rest / radix_now;
			end while (rest != 0);
			kept = (lsd_first.size() > MAX_DIGITS) ? MAX_DIGITS : lsd_first.size();
			for (int k = kept - 1; k >= 0; k--) begin
				d.digit      = lsd_first[k];
				d.digit_char = ascii_of(lsd_first[k]);
				d.last       = (k == 0);
				owed_digits.push_back(d);
			end
		endfunction

		function void report(input string what, input int unsigned want, input int unsigned got);
			if (mismatches < REPORT_CAP) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			end
		endfunction

		function void check_digit(input digit_t got);
			digit_t want;
			if (owed_digits.size() == 0) begin
				if (mismatches < REPORT_CAP) begin
					$display("%0t: unexpected digit, expected none actual %0d", $time, got.digit);
				end
				mismatches++;
				return;
			end
			want = owed_digits.pop_front();
			if (want !== got) begin
				if (want.digit !== got.digit) report("digit", want.digit, got.digit);
				if (want.digit_char !== got.digit_char) begin
					report("digit_char", want.digit_char, got.digit_char);
				end
				if (want.last !== got.last) report("last", want.last, got.last);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return owed_digits.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [RADIX_W-1:0]  cfg_wdata;

	rdc_in_if  in_ch ();
	rdc_out_if out_ch ();

	radix_digit_converter_top #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	digit_tracker board = new();

	int unsigned burst_left = 0;   // transfers left in the current sender burst
	longint      cycle_count = 0;

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// offer one value, with a random gap whenever a burst runs out
	task automatic offer_value(input logic [VALUE_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		// the transfer happens on the first edge that sees ready high
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		board.note_value(v);
		burst_left--;
	endtask

	// stop offering, wait out every owed digit plus the block's tail
	task automatic drain_digits();
		in_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only called with the block idle
	task automatic write_radix(input logic [RADIX_W-1:0] wdata);
		cfg_we    <= 1'b1;
		cfg_wdata <= wdata;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_radix(wdata);
		burst_left = 0;
	endtask

	// random value shaped to hit small values, powers of the base and all widths
	function automatic logic [VALUE_W-1:0] pick_value(input int unsigned base);
		bit [63:0]   power;
		int unsigned steps;
		case ($urandom_range(0, 9))
			0, 1: return VALUE_W'($urandom_range(0, base - 1));   // one digit, letters too
			2: begin
				power = 1;
				steps = $urandom_range(1, 32);
				while (steps > 0 && power * base <= OPERAND_MASK) begin
					power = power * base;
					steps--;
				end
				case ($urandom_range(0, 3))
					0: return VALUE_W'(power);
					1: return VALUE_W'(power - 1);   // every digit at its top value
					2: return VALUE_W'(power + 1);
					default: return {VALUE_W{1'b1}};
				endcase
			end
			3, 4: return VALUE_W'($urandom >> $urandom_range(0, 31));
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// receiver: check each transfer, then choose ready for the next edge
	initial begin : receiver
		int unsigned run_left;
		int unsigned hold_left;
		int unsigned digits_seen;
		bit          run_ready;
		bit          held_off;
		digit_t      got;
		run_left    = 0;
		hold_left   = 0;
		digits_seen = 0;
		run_ready   = 1'b1;
		held_off    = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.digit      = out_ch.digit;
				got.digit_char = out_ch.digit_char;
				got.last       = out_ch.last;
				board.check_digit(got);
				digits_seen++;
			end
			// one long hold-off so the queue fills and the input stalls
			if (!held_off && digits_seen >= HOLD_AFTER) begin
				held_off  = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_ready = ($urandom_range(0, 3) != 0);
					if (run_ready) begin
						run_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
					end else begin
						run_left = $urandom_range(1, 6);
					end
				end
				run_left--;
				out_ch.ready <= run_ready;
			end
		end
	end

	// timeout guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [RADIX_W-1:0] phase_radix[10];
		phase_radix = '{5'd0, 5'd31, 5'd16, 5'd2, 5'd1, 5'd17, 5'd7, 5'd10, 5'd3, 5'd12};

		// every input known from time zero
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_ch.valid <= 1'b0;
		in_ch.value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset radix of ten first, no write yet
		offer_value(32'd0);             // zero gives the single digit 0
		offer_value(32'd1);
		offer_value(32'd9);
		offer_value(32'd10);
		offer_value(32'd99);
		offer_value(32'd100);
		offer_value(32'd999999999);
		offer_value(32'd1000000000);
		offer_value(32'h8000_0000);
		offer_value(32'hFFFF_FFFF);
		drain_digits();

		// radix write below range clamps to two: the longest digit strings
		write_radix(5'd0);
		offer_value(32'd0);
		offer_value(32'd1);
		offer_value(32'd2);
		offer_value(32'hFFFF_FFFF);     // 32 digits, the full digit store
		offer_value(32'h8000_0000);
		drain_digits();

		// radix write above range clamps to sixteen
		write_radix(5'd31);
		offer_value(32'd10);            // below the base: one letter digit
		offer_value(32'd15);
		offer_value(32'd16);
		offer_value(32'd255);
		offer_value(32'hDEAD_BEEF);
		offer_value(32'hFFFF_FFFF);
		offer_value(32'd0);
		drain_digits();

		write_radix(5'd17);
		offer_value(32'h0ABC_DEF0);
		drain_digits();

		write_radix(5'd1);
		offer_value(32'd5);
		drain_digits();

		// random phases across several radix settings, extremes included
		foreach (phase_radix[p]) begin
			write_radix(phase_radix[p]);
			repeat (RANDOM_ITEMS) offer_value(pick_value(board.radix_now));
			drain_digits();
		end

		if (board.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
